/* hw/rtl/bas_pkg.sv */
// ----------------------------------------------------------------------------
// bas_pkg - bus address self-assignment shared definitions
// field widths, command, frame type and role codes, register indexes
// ----------------------------------------------------------------------------
package bas_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int NONCE_W = 32;
   localparam int RTYPE_W = 4;
   localparam int RLEN_W  = 8;
   localparam int HEAD_W  = 40;
   localparam int TTYPE_W = 2;
   localparam int ADDR_W  = 8;
   localparam int TLEN_W  = 3;
   localparam int ROLE_W  = 2;
   localparam int ID_W    = 8;
   localparam int MS_W    = 16;
   localparam int SLOT_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [TTYPE_W-1:0] frame_type;
   typedef logic [ROLE_W-1:0]  role_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // commands
   localparam cmd_type CMD_START = 2'd0;
   localparam cmd_type CMD_FRAME = 2'd1;
   localparam cmd_type CMD_TICK  = 2'd2;

   // frame types
   localparam frame_type FT_CLAIM  = 2'd0;
   localparam frame_type FT_HELLO  = 2'd1;
   localparam frame_type FT_JOIN   = 2'd2;
   localparam frame_type FT_ASSIGN = 2'd3;

   // payload lengths
   localparam logic [TLEN_W-1:0] LEN_HELLO  = 3'd0;
   localparam logic [TLEN_W-1:0] LEN_NONCE  = 3'd4;
   localparam logic [TLEN_W-1:0] LEN_ASSIGN = 3'd5;

   // roles
   localparam role_type ROLE_SEEK   = 2'd0;
   localparam role_type ROLE_COORD  = 2'd1;
   localparam role_type ROLE_MEMBER = 2'd2;

   // ids
   localparam logic [ID_W-1:0] ID_COORD      = 8'd1;
   localparam logic [ID_W-1:0] ID_FIRST_FREE = 8'd2;
   localparam logic [ADDR_W-1:0] ADDR_ASSIGN = 8'd1;

   // register indexes
   localparam csr_idx_type CSR_INSTANCE_SLOT = 3'd0;
   localparam csr_idx_type CSR_SLOT_MS       = 3'd1;
   localparam csr_idx_type CSR_LISTEN_MS     = 3'd2;
   localparam csr_idx_type CSR_CONTEST_MS    = 3'd3;
   localparam csr_idx_type CSR_RETRY_MS      = 3'd4;

   // register reset values
   localparam logic [SLOT_W-1:0] RST_INSTANCE_SLOT = 8'd0;
   localparam logic [SLOT_W-1:0] RST_SLOT_MS       = 8'd150;
   localparam logic [MS_W-1:0]   RST_LISTEN_MS     = 16'd200;
   localparam logic [MS_W-1:0]   RST_CONTEST_MS    = 16'd150;
   localparam logic [MS_W-1:0]   RST_RETRY_MS      = 16'd250;

endpackage

/* hw/rtl/bas_if.sv */
// ----------------------------------------------------------------------------
// bas_if - request and response channel interfaces
// valid/ready channels carrying the node's command and result transactions
// ----------------------------------------------------------------------------
interface bas_req_if;
   logic                        valid;
   logic                        ready;
   bas_pkg::cmd_type            cmd;
   logic [bas_pkg::NONCE_W-1:0] claim_rand;
   logic [bas_pkg::NONCE_W-1:0] join_rand;
   logic                        rx_ok;
   logic [bas_pkg::RTYPE_W-1:0] rx_type;
   logic [bas_pkg::RLEN_W-1:0]  rx_len;
   logic [bas_pkg::HEAD_W-1:0]  rx_head;

   modport source (output valid, cmd, claim_rand, join_rand, rx_ok, rx_type, rx_len,
                   rx_head, input ready);
   modport sink (input valid, cmd, claim_rand, join_rand, rx_ok, rx_type, rx_len,
                 rx_head, output ready);
endinterface

interface bas_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        tx_valid;
   bas_pkg::frame_type          tx_type;
   logic [bas_pkg::ADDR_W-1:0]  tx_addr;
   logic [bas_pkg::TLEN_W-1:0]  tx_len;
   logic [bas_pkg::HEAD_W-1:0]  tx_body;
   logic                        last;
   bas_pkg::role_type           role_now;
   logic [bas_pkg::ID_W-1:0]    node_id;

   modport source (output valid, tx_valid, tx_type, tx_addr, tx_len, tx_body, last,
                   role_now, node_id, input ready);
   modport sink (input valid, tx_valid, tx_type, tx_addr, tx_len, tx_body, last,
                 role_now, node_id, output ready);
endinterface

/* hw/rtl/bus_address_self_assignment_core.sv */
// ----------------------------------------------------------------------------
// bus_address_self_assignment_core - bus node address self-assignment
// startup claim contest, join/assign handshake and coordinator dedup scan
// ----------------------------------------------------------------------------
// Each request transaction is a start command, a received frame summary or a
// one-millisecond tick, and produces one or two response transactions; last
// marks the final one, and role_now/node_id give the node state after the
// command. The block takes one request at a time: a request is registered,
// decoded in the following cycle, and its results are then offered on the
// response channel until taken, so response backpressure holds the block. A
// JOIN frame received by the coordinator walks the dedup ram one entry per
// cycle through a single 32-bit equality comparator, up to the fill count,
// and stops early on a hit. The dedup ram needs no clearing pass: a fill
// count bounds the scan and a start command resets it. Register writes on the
// csr port take effect at once and are expected only while the node is idle.
// ----------------------------------------------------------------------------
module bus_address_self_assignment_core #(
   parameter int DEDUP_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   bas_req_if.sink                         req_ch,
   bas_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [bas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bas_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   localparam int AW = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1;
   localparam int FW = $clog2(DEDUP_DEPTH + 1);
   localparam logic [AW-1:0] WPTR_LAST = AW'(DEDUP_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX  = FW'(DEDUP_DEPTH);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } seq_state_type;

   // startup phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DELAY,
      PH_LISTEN,
      PH_CONTEST,
      PH_RUN
   } phase_type;

   // configuration registers
   logic [bas_pkg::SLOT_W-1:0] instance_slot_ff;
   logic [bas_pkg::SLOT_W-1:0] slot_ms_ff;
   logic [bas_pkg::MS_W-1:0]   listen_ms_ff;
   logic [bas_pkg::MS_W-1:0]   contest_ms_ff;
   logic [bas_pkg::MS_W-1:0]   retry_ms_ff;

   // control state
   seq_state_type                state_ff, state_in;
   phase_type                    phase_ff, phase_in;
   bas_pkg::role_type            role_ff, role_in;
   logic [bas_pkg::ID_W-1:0]     my_id_ff, my_id_in;
   logic [bas_pkg::ID_W-1:0]     next_id_ff, next_id_in;
   logic [bas_pkg::NONCE_W-1:0]  contest_nonce_ff, contest_nonce_in;
   logic [bas_pkg::NONCE_W-1:0]  request_nonce_ff, request_nonce_in;
   logic [bas_pkg::MS_W-1:0]     phase_timer_ff, phase_timer_in;
   logic [bas_pkg::MS_W-1:0]     retry_timer_ff, retry_timer_in;
   logic [FW-1:0]                dedup_fill_ff, dedup_fill_in;
   logic [AW-1:0]                dedup_wptr_ff, dedup_wptr_in;
   logic [FW-1:0]                scan_idx_ff, scan_idx_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic                         two_ff, two_in;

   // latched request transaction
   bas_pkg::cmd_type             cmd_ff;
   logic [bas_pkg::NONCE_W-1:0]  claim_rand_ff;
   logic [bas_pkg::NONCE_W-1:0]  join_rand_ff;
   logic                         rx_ok_ff;
   logic [bas_pkg::RTYPE_W-1:0]  rx_type_ff;
   logic [bas_pkg::RLEN_W-1:0]   rx_len_ff;
   logic [bas_pkg::HEAD_W-1:0]   rx_head_ff;

   // response frame register
   logic                         tx_valid_ff, tx_valid_in;
   bas_pkg::frame_type           tx_type_ff, tx_type_in;
   logic [bas_pkg::ADDR_W-1:0]   tx_addr_ff, tx_addr_in;
   logic [bas_pkg::TLEN_W-1:0]   tx_len_ff, tx_len_in;
   logic [bas_pkg::HEAD_W-1:0]   tx_body_ff, tx_body_in;

   // decode helpers
   logic                         req_acc;
   logic                         rsp_acc;
   logic [bas_pkg::NONCE_W-1:0]  nonce4;
   logic [bas_pkg::MS_W-1:0]     start_delay;
   logic [bas_pkg::MS_W-1:0]     delay_dec;
   logic [bas_pkg::MS_W-1:0]     retry_inc;
   logic                         len_ge4;
   logic                         len_ge5;

   // dedup ram
   logic                         ram_we;
   logic [AW-1:0]                ram_raddr;
   logic [bas_pkg::NONCE_W-1:0]  ram_rdata;
   logic                         scan_hit;
   logic                         scan_done;

   assign req_acc = req_ch.valid & req_ch.ready;
   assign rsp_acc = rsp_ch.valid & rsp_ch.ready;

   assign nonce4      = rx_head_ff[bas_pkg::HEAD_W-1:8];
   assign start_delay = instance_slot_ff * slot_ms_ff;
   assign delay_dec   = (phase_timer_ff != '0) ? phase_timer_ff - 1'b1 : phase_timer_ff;
   assign retry_inc   = (retry_timer_ff != '1) ? retry_timer_ff + 1'b1 : retry_timer_ff;
   assign len_ge4     = rx_len_ff >= bas_pkg::RLEN_W'(bas_pkg::LEN_NONCE);
   assign len_ge5     = rx_len_ff >= bas_pkg::RLEN_W'(bas_pkg::LEN_ASSIGN);

   // the shared comparator: one stored nonce per cycle against the join nonce
   assign scan_hit  = cmp_vld_ff && (ram_rdata == nonce4);
   assign scan_done = (scan_idx_ff == dedup_fill_ff) && !cmp_vld_ff;
   assign ram_raddr = scan_idx_ff[AW-1:0];

   bas_ram #(
      .WIDTH (bas_pkg::NONCE_W),
      .DEPTH (DEDUP_DEPTH)
   ) u_dedup_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dedup_wptr_ff),
      .wr_data (nonce4),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // csr writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         instance_slot_ff <= bas_pkg::RST_INSTANCE_SLOT;
         slot_ms_ff       <= bas_pkg::RST_SLOT_MS;
         listen_ms_ff     <= bas_pkg::RST_LISTEN_MS;
         contest_ms_ff    <= bas_pkg::RST_CONTEST_MS;
         retry_ms_ff      <= bas_pkg::RST_RETRY_MS;
      end else if (csr_we) begin
         case (csr_index)
            bas_pkg::CSR_INSTANCE_SLOT: instance_slot_ff <= csr_wdata[bas_pkg::SLOT_W-1:0];
            bas_pkg::CSR_SLOT_MS:       slot_ms_ff       <= csr_wdata[bas_pkg::SLOT_W-1:0];
            bas_pkg::CSR_LISTEN_MS:     listen_ms_ff     <= csr_wdata;
            bas_pkg::CSR_CONTEST_MS:    contest_ms_ff    <= csr_wdata;
            bas_pkg::CSR_RETRY_MS:      retry_ms_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // next-state logic of the sequencer and node state
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      role_in          = role_ff;
      my_id_in         = my_id_ff;
      next_id_in       = next_id_ff;
      contest_nonce_in = contest_nonce_ff;
      request_nonce_in = request_nonce_ff;
      phase_timer_in   = phase_timer_ff;
      retry_timer_in   = retry_timer_ff;
      dedup_fill_in    = dedup_fill_ff;
      dedup_wptr_in    = dedup_wptr_ff;
      scan_idx_in      = scan_idx_ff;
      cmp_vld_in       = 1'b0;
      two_in           = two_ff;
      tx_valid_in      = tx_valid_ff;
      tx_type_in       = tx_type_ff;
      tx_addr_in       = tx_addr_ff;
      tx_len_in        = tx_len_ff;
      tx_body_in       = tx_body_ff;
      ram_we           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            // default result: nothing to transmit
            tx_valid_in = 1'b0;
            tx_type_in  = bas_pkg::FT_CLAIM;
            tx_addr_in  = '0;
            tx_len_in   = bas_pkg::LEN_HELLO;
            tx_body_in  = '0;
            two_in      = 1'b0;
            state_in    = ST_EMIT;

            case (cmd_ff)
               bas_pkg::CMD_START: begin
                  role_in          = bas_pkg::ROLE_SEEK;
                  my_id_in         = '0;
                  next_id_in       = '0;
                  contest_nonce_in = claim_rand_ff;
                  request_nonce_in = join_rand_ff;
                  dedup_fill_in    = '0;
                  dedup_wptr_in    = '0;
                  retry_timer_in   = '0;
                  if (start_delay == '0) begin
                     phase_in       = PH_LISTEN;
                     phase_timer_in = listen_ms_ff;
                  end else begin
                     phase_in       = PH_DELAY;
                     phase_timer_in = start_delay;
                  end
               end

               bas_pkg::CMD_FRAME: begin
                  if (rx_ok_ff) begin
                     case (phase_ff)
                        PH_LISTEN, PH_CONTEST: begin
                           // someone already claimed, or a higher claim beat ours
                           if ((rx_type_ff == {2'b00, bas_pkg::FT_CLAIM}) &&
                               ((phase_ff == PH_LISTEN) ||
                                (len_ge4 && (nonce4 > contest_nonce_ff)))) begin
                              tx_valid_in    = 1'b1;
                              tx_type_in     = bas_pkg::FT_HELLO;
                              two_in         = 1'b1;
                              phase_in       = PH_RUN;
                              role_in        = bas_pkg::ROLE_SEEK;
                              retry_timer_in = '0;
                           end
                        end
                        PH_RUN: begin
                           if ((role_ff == bas_pkg::ROLE_COORD) &&
                               (rx_type_ff == {2'b00, bas_pkg::FT_JOIN}) && len_ge4) begin
                              scan_idx_in = '0;
                              state_in    = ST_SCAN;
                           end else if ((role_ff == bas_pkg::ROLE_SEEK) &&
                                        (rx_type_ff == {2'b00, bas_pkg::FT_ASSIGN}) &&
                                        len_ge5 &&
                                        (rx_head_ff[bas_pkg::NONCE_W-1:0] ==
                                         request_nonce_ff)) begin
                              my_id_in = rx_head_ff[bas_pkg::HEAD_W-1:bas_pkg::NONCE_W];
                              role_in  = bas_pkg::ROLE_MEMBER;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end

               bas_pkg::CMD_TICK: begin
                  case (phase_ff)
                     PH_DELAY: begin
                        phase_timer_in = delay_dec;
                        if (delay_dec == '0) begin
                           phase_in       = PH_LISTEN;
                           phase_timer_in = listen_ms_ff;
                        end
                     end
                     PH_LISTEN: begin
                        if (phase_timer_ff > 16'd1) begin
                           phase_timer_in = delay_dec;
                        end else begin
                           tx_valid_in    = 1'b1;
                           tx_type_in     = bas_pkg::FT_CLAIM;
                           tx_len_in      = bas_pkg::LEN_NONCE;
                           tx_body_in     = {contest_nonce_ff, 8'h00};
                           phase_in       = PH_CONTEST;
                           phase_timer_in = contest_ms_ff;
                        end
                     end
                     PH_CONTEST: begin
                        if (phase_timer_ff > 16'd1) begin
                           phase_timer_in = delay_dec;
                        end else begin
                           phase_in       = PH_RUN;
                           role_in        = bas_pkg::ROLE_COORD;
                           my_id_in       = bas_pkg::ID_COORD;
                           next_id_in     = bas_pkg::ID_FIRST_FREE;
                           phase_timer_in = '0;
                        end
                     end
                     PH_RUN: begin
                        if (role_ff == bas_pkg::ROLE_SEEK) begin
                           retry_timer_in = retry_inc;
                           if (retry_inc >= retry_ms_ff) begin
                              tx_valid_in    = 1'b1;
                              tx_type_in     = bas_pkg::FT_JOIN;
                              tx_len_in      = bas_pkg::LEN_NONCE;
                              tx_body_in     = {request_nonce_ff, 8'h00};
                              retry_timer_in = '0;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end

               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            if (scan_hit) begin
               // nonce already served, stay silent
               state_in = ST_EMIT;
            end else if (scan_done) begin
               // new nonce: record round-robin and hand out the next id
               ram_we        = 1'b1;
               dedup_wptr_in = (dedup_wptr_ff == WPTR_LAST) ? '0 : dedup_wptr_ff + 1'b1;
               if (dedup_fill_ff != FILL_MAX) begin
                  dedup_fill_in = dedup_fill_ff + 1'b1;
               end
               tx_valid_in = 1'b1;
               tx_type_in  = bas_pkg::FT_ASSIGN;
               tx_addr_in  = bas_pkg::ADDR_ASSIGN;
               tx_len_in   = bas_pkg::LEN_ASSIGN;
               tx_body_in  = {next_id_ff, nonce4};
               next_id_in  = next_id_ff + 1'b1;
               state_in    = ST_EMIT;
            end else if (scan_idx_ff != dedup_fill_ff) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               cmp_vld_in  = 1'b1;
            end
         end

         ST_EMIT: begin
            if (rsp_acc) begin
               if (two_ff) begin
                  // second transaction of a hello/join pair
                  two_in      = 1'b0;
                  tx_valid_in = 1'b1;
                  tx_type_in  = bas_pkg::FT_JOIN;
                  tx_addr_in  = '0;
                  tx_len_in   = bas_pkg::LEN_NONCE;
                  tx_body_in  = {request_nonce_ff, 8'h00};
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_ff         <= PH_IDLE;
         role_ff          <= bas_pkg::ROLE_SEEK;
         my_id_ff         <= '0;
         next_id_ff       <= '0;
         contest_nonce_ff <= '0;
         request_nonce_ff <= '0;
         phase_timer_ff   <= '0;
         retry_timer_ff   <= '0;
         dedup_fill_ff    <= '0;
         dedup_wptr_ff    <= '0;
         scan_idx_ff      <= '0;
         cmp_vld_ff       <= 1'b0;
         two_ff           <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         role_ff          <= role_in;
         my_id_ff         <= my_id_in;
         next_id_ff       <= next_id_in;
         contest_nonce_ff <= contest_nonce_in;
         request_nonce_ff <= request_nonce_in;
         phase_timer_ff   <= phase_timer_in;
         retry_timer_ff   <= retry_timer_in;
         dedup_fill_ff    <= dedup_fill_in;
         dedup_wptr_ff    <= dedup_wptr_in;
         scan_idx_ff      <= scan_idx_in;
         cmp_vld_ff       <= cmp_vld_in;
         two_ff           <= two_in;
      end
      tx_valid_ff <= tx_valid_in;
      tx_type_ff  <= tx_type_in;
      tx_addr_ff  <= tx_addr_in;
      tx_len_ff   <= tx_len_in;
      tx_body_ff  <= tx_body_in;
   end

   // request transaction capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff        <= req_ch.cmd;
         claim_rand_ff <= req_ch.claim_rand;
         join_rand_ff  <= req_ch.join_rand;
         rx_ok_ff      <= req_ch.rx_ok;
         rx_type_ff    <= req_ch.rx_type;
         rx_len_ff     <= req_ch.rx_len;
         rx_head_ff    <= req_ch.rx_head;
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid    = (state_ff == ST_EMIT);
   assign rsp_ch.tx_valid = tx_valid_ff;
   assign rsp_ch.tx_type  = tx_type_ff;
   assign rsp_ch.tx_addr  = tx_addr_ff;
   assign rsp_ch.tx_len   = tx_len_ff;
   assign rsp_ch.tx_body  = tx_body_ff;
   assign rsp_ch.last     = !two_ff;
   assign rsp_ch.role_now = role_ff;
   assign rsp_ch.node_id  = my_id_ff;

   // a new command is never taken while results are still pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while response pending");

   // dedup ram is written only at the end of a lookup that missed
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_SCAN) && !cmp_vld_ff)
      else $error("dedup write outside lookup");

   // fill count never passes the ram depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      dedup_fill_ff <= FILL_MAX)
      else $error("dedup fill overflow");

   // the coordinator always holds id 1
   a_coord_id: assert property (@(posedge clock) disable iff (reset)
      (role_ff == bas_pkg::ROLE_COORD) |-> (my_id_ff == bas_pkg::ID_COORD))
      else $error("coordinator id mismatch");

endmodule

/* hw/rtl/bas_ram.sv */
// ----------------------------------------------------------------------------
// bas_ram - generic single-write, single-read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module bas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
